[src/tsx_pkg.sv]
package tsx_pkg;

  localparam int PACKET_BYTES    = 188;
  localparam int MAGIC_LENGTH    = 12;
  localparam int MAX_NAME_LENGTH = 254;
  localparam int POS_W           = $clog2(PACKET_BYTES);
  localparam int MP_W            = $clog2(MAGIC_LENGTH + 1);

  localparam logic [7:0]  SYNC_VALUE   = 8'h47;
  localparam logic [7:0]  PES_AUDIO_ID = 8'hBD;
  localparam logic [7:0]  AC3_FIRST    = 8'h0B;
  localparam logic [7:0]  AC3_SECOND   = 8'h77;
  localparam logic [12:0] PID_RESET    = 13'd6530;
  localparam logic [4:0]  HEADER_BYTES = 5'd18;

  localparam logic [7:0] MAGIC [16] = '{
    8'hCA, 8'hFE, 8'hC0, 8'hDE, 8'hF0, 8'h0D, 8'hCA, 8'hFE,
    8'hC0, 8'hDE, 8'hF0, 8'h0D, 8'hCA, 8'hFE, 8'hC0, 8'hDE
  };

  typedef enum logic [2:0] {
    KIND_NAME      = 3'd0,
    KIND_FILE      = 3'd1,
    KIND_ANNOUNCE  = 3'd2,
    KIND_SYNC_ERR  = 3'd3,
    KIND_NAME_LONG = 3'd4,
    KIND_ADAPT_ERR = 3'd5
  } kind_t;

  localparam logic OP_BYTE  = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  typedef struct packed {
    logic       accept;
    logic       sync_err;
    logic       adapt_err;
    logic [7:0] start;
  } desc_t;

  typedef struct packed {
    logic             valid;
    logic [POS_W-1:0] pos;
    desc_t            desc;
  } replay_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data_byte;
    logic [63:0] announced_size;
    logic [7:0]  announced_name_length;
    logic        last;
  } result_t;

  // KMP step: longest prefix of the magic that ends the matched text plus b
  function automatic logic [MP_W-1:0] magic_next(input logic [MP_W-1:0] q,
                                                 input logic [7:0] b);
    logic [MP_W-1:0] res;
    logic            ok;
    res = '0;
    for (int k = 1; k <= MAGIC_LENGTH; k++) begin
      ok = (k <= int'(q) + 1) && (MAGIC[k-1] == b);
      for (int j = 0; j < k - 1; j++) begin
        if (MAGIC[j] != MAGIC[4'((int'(q) + 1 - k + j) & 15)]) begin
          ok = 1'b0;
        end
      end
      if (ok) begin
        res = MP_W'(k);
      end
    end
    return res;
  endfunction

endpackage

[src/tsx_loader.sv]
module tsx_loader (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      accept,
  input  logic                      opcode,
  input  logic [7:0]                stream_byte,
  input  logic [12:0]               target_pid,
  output tsx_pkg::replay_t          rp,
  output logic [7:0]                rd_data
);
  import tsx_pkg::*;

  logic [7:0]       store [PACKET_BYTES];
  logic [POS_W-1:0] load_position;
  logic             previous_valid;
  logic             drain_seen;
  desc_t            replay_desc;

  logic             sync_ok;
  logic [12:0]      pid;
  logic [1:0]       afc;
  logic [8:0]       p_reg;
  logic [8:0]       h;
  logic             pes_ok;
  logic             ac3_ok;

  logic [9:0]       off;
  logic             in_pay;
  logic             last_pos;
  desc_t            desc_next;
  logic [8:0]       skip;
  logic [9:0]       end_ac3;

  assign off      = {2'b0, load_position} - {1'b0, p_reg};
  assign in_pay   = {1'b0, load_position} >= p_reg;
  assign last_pos = load_position == POS_W'(PACKET_BYTES - 1);
  assign end_ac3  = {1'b0, p_reg} + {1'b0, h} + 10'd7;

  always_comb begin
    desc_next = '0;
    skip      = '0;
    if (!sync_ok) begin
      desc_next.sync_err = 1'b1;
    end else if (pid == target_pid && (afc == 2'd1 || afc == 2'd3)) begin
      if (p_reg > 9'(PACKET_BYTES)) begin
        desc_next.adapt_err = 1'b1;
      end else begin
        if (p_reg <= 9'(PACKET_BYTES - 9) && pes_ok && ac3_ok &&
            end_ac3 <= 10'(PACKET_BYTES)) begin
          skip = h + 9'd7;
        end
        desc_next.accept = 1'b1;
        desc_next.start  = 8'(p_reg + skip);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data <= store[load_position];
      if (opcode == OP_BYTE) begin
        store[load_position] <= stream_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_position  <= '0;
      previous_valid <= 1'b0;
      drain_seen     <= 1'b0;
      replay_desc    <= '0;
      rp             <= '0;
    end else begin
      rp.valid <= accept && previous_valid;
      if (accept) begin
        rp.pos  <= load_position;
        rp.desc <= replay_desc;
        if (last_pos) begin
          load_position  <= '0;
          previous_valid <= !(drain_seen || opcode == OP_DRAIN);
          replay_desc    <= desc_next;
          drain_seen     <= 1'b0;
        end else begin
          load_position <= load_position + 1'b1;
          drain_seen    <= drain_seen || opcode == OP_DRAIN;
        end
      end
    end
  end

  // header tracking from the incoming bytes of the packet being loaded
  always_ff @(posedge clk) begin
    if (accept && opcode == OP_BYTE) begin
      if (load_position == '0) begin
        sync_ok <= stream_byte == SYNC_VALUE;
        p_reg   <= '1;
        pes_ok  <= 1'b1;
        ac3_ok  <= 1'b1;
        h       <= '1;
      end
      if (load_position == POS_W'(1)) pid[12:8] <= stream_byte[4:0];
      if (load_position == POS_W'(2)) pid[7:0]  <= stream_byte;
      if (load_position == POS_W'(3)) begin
        afc <= stream_byte[5:4];
        if (stream_byte[5:4] == 2'd1) p_reg <= 9'd4;
      end
      if (load_position == POS_W'(4) && afc == 2'd3) begin
        p_reg <= 9'd5 + {1'b0, stream_byte};
      end
      if (in_pay) begin
        if ((off == 10'd0 && stream_byte != 8'h00) ||
            (off == 10'd1 && stream_byte != 8'h00) ||
            (off == 10'd2 && stream_byte != 8'h01) ||
            (off == 10'd3 && stream_byte != PES_AUDIO_ID)) begin
          pes_ok <= 1'b0;
        end
        if (off == 10'd8) h <= 9'd9 + {1'b0, stream_byte};
        if ((off == {1'b0, h} && stream_byte != AC3_FIRST) ||
            (off == {1'b0, h} + 10'd1 && stream_byte != AC3_SECOND)) begin
          ac3_ok <= 1'b0;
        end
      end
    end
  end

endmodule

[src/tsx_extract.sv]
module tsx_extract (
  input  logic                 clk,
  input  logic                 rst,
  input  tsx_pkg::replay_t     rp,
  input  logic [7:0]           b,
  output logic                 push,
  output tsx_pkg::result_t     res
);
  import tsx_pkg::*;

  typedef enum logic [1:0] {SEARCH, HEADER, NAME, FILE} phase_t;

  phase_t          phase;
  logic [MP_W-1:0] magic_progress;
  logic [4:0]      header_progress;
  logic [63:0]     hf0;
  logic [63:0]     hf1;
  logic [63:0]     bytes_done;
  logic            skip_rest;

  logic [MP_W-1:0] mq;
  logic [4:0]      hp_next;
  logic [63:0]     hf1_next;
  logic [63:0]     bd_next;

  assign mq       = magic_next(magic_progress, b);
  assign hp_next  = header_progress + 5'd1;
  assign hf1_next = {b, hf1[63:8]};
  assign bd_next  = bytes_done + 64'd1;

  always_ff @(posedge clk) begin
    logic    push_next;
    result_t res_next;
    push_next = 1'b0;
    res_next  = '0;
    if (rst) begin
      phase           <= SEARCH;
      magic_progress  <= '0;
      header_progress <= '0;
      hf0             <= '0;
      hf1             <= '0;
      bytes_done      <= '0;
      skip_rest       <= 1'b0;
      push            <= 1'b0;
    end else begin
      if (rp.valid) begin
        if (rp.pos == '0) begin
          skip_rest <= 1'b0;
          if (rp.desc.sync_err) begin
            push_next     = 1'b1;
            res_next.kind = KIND_SYNC_ERR;
          end else if (rp.desc.adapt_err) begin
            push_next     = 1'b1;
            res_next.kind = KIND_ADAPT_ERR;
          end
        end else if (rp.desc.accept && !skip_rest && 8'(rp.pos) >= rp.desc.start) begin
          case (phase)
            SEARCH: begin
              if (mq >= MP_W'(MAGIC_LENGTH)) begin
                phase           <= HEADER;
                magic_progress  <= '0;
                header_progress <= '0;
                hf0             <= '0;
                hf1             <= '0;
              end else begin
                magic_progress <= mq;
              end
            end
            HEADER: begin
              if (header_progress >= 5'd2 && header_progress < 5'd10) begin
                hf0 <= {b, hf0[63:8]};
              end else if (header_progress >= 5'd10) begin
                hf1 <= hf1_next;
              end
              if (hp_next < HEADER_BYTES) begin
                header_progress <= hp_next;
              end else begin
                header_progress <= '0;
                bytes_done      <= '0;
                push_next       = 1'b1;
                if (hf0 > 64'(MAX_NAME_LENGTH)) begin
                  phase          <= SEARCH;
                  magic_progress <= '0;
                  res_next.kind  = KIND_NAME_LONG;
                end else begin
                  res_next.kind                  = KIND_ANNOUNCE;
                  res_next.announced_size        = hf1_next;
                  res_next.announced_name_length = hf0[7:0];
                  if (hf0 != '0) begin
                    phase <= NAME;
                  end else if (hf1_next != '0) begin
                    phase <= FILE;
                  end else begin
                    phase          <= SEARCH;
                    magic_progress <= '0;
                    skip_rest      <= 1'b1;
                  end
                end
              end
            end
            NAME: begin
              push_next          = 1'b1;
              res_next.kind      = KIND_NAME;
              res_next.data_byte = b;
              if (bd_next >= hf0) begin
                res_next.last = 1'b1;
                bytes_done    <= '0;
                if (hf1 != '0) begin
                  phase <= FILE;
                end else begin
                  phase          <= SEARCH;
                  magic_progress <= '0;
                  skip_rest      <= 1'b1;
                end
              end else begin
                bytes_done <= bd_next;
              end
            end
            default: begin
              push_next          = 1'b1;
              res_next.kind      = KIND_FILE;
              res_next.data_byte = b;
              if (bd_next >= hf1) begin
                res_next.last   = 1'b1;
                bytes_done      <= '0;
                phase           <= SEARCH;
                magic_progress  <= '0;
                header_progress <= '0;
                skip_rest       <= 1'b1;
              end else begin
                bytes_done <= bd_next;
              end
            end
          endcase
        end
      end
      push <= push_next;
      res  <= res_next;
    end
  end

endmodule

[src/tsx_out_fifo.sv]
module tsx_out_fifo (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  tsx_pkg::result_t     din,
  input  logic                 pop_ready,
  output logic                 out_valid,
  output tsx_pkg::result_t     dout,
  output logic [2:0]           count
);
  import tsx_pkg::*;

  result_t    mem [4];
  logic [1:0] head;
  logic [1:0] tail;
  logic       pop;

  assign out_valid = count != 3'd0;
  assign pop       = out_valid && pop_ready;
  assign dout      = mem[head];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[tail] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) tail <= tail + 2'd1;
      if (pop)  head <= head + 2'd1;
      count <= count + {2'b0, push} - {2'b0, pop};
    end
  end

endmodule

[src/ts_embedded_file_extractor.sv]
// A replayed byte's result goes through the replay, result and FIFO registers.
// Throughput: one item per cycle; the packet store is read and written at one
// address per item, the extractor state updates once per cycle. Input stalls only
// when the 4-entry result FIFO plus the two pipeline stages hold 4 results.
// Reset: synchronous, active high; clears control state and sets target_pid to 6530.
// The packet store is not cleared; a packet is replayed only after a full load.
module ts_embedded_file_extractor (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // stream_byte
  input  logic        s_axis_tuser,   // opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,   // data_byte, announced_size, announced_name_length
  output logic [2:0]  m_axis_tuser,   // kind
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tsx_pkg::*;

  logic [12:0] target_pid;
  replay_t     rp;
  logic [7:0]  rd_data;
  logic        push;
  result_t     res;
  result_t     dout;
  logic [2:0]  count;
  logic        accept;

  assign pready        = 1'b1;
  assign prdata        = {19'b0, target_pid};
  assign s_axis_tready = (count + {2'b0, push} + {2'b0, rp.valid}) < 3'd4;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_pid <= PID_RESET;
    end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
      target_pid <= pwdata[12:0];
    end
  end

  tsx_loader u_loader (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .opcode      (s_axis_tuser),
    .stream_byte (s_axis_tdata),
    .target_pid  (target_pid),
    .rp          (rp),
    .rd_data     (rd_data)
  );

  tsx_extract u_extract (
    .clk  (clk),
    .rst  (rst),
    .rp   (rp),
    .b    (rd_data),
    .push (push),
    .res  (res)
  );

  tsx_out_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .din       (res),
    .pop_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .dout      (dout),
    .count     (count)
  );

  assign m_axis_tuser = dout.kind;
  assign m_axis_tdata = {dout.announced_name_length, dout.announced_size, dout.data_byte};
  assign m_axis_tlast = dout.last;

endmodule

[sim/tb_ts_embedded_file_extractor.sv]
`timescale 1ns / 1ps

module tb_ts_embedded_file_extractor;
  import tsx_pkg::*;

  typedef struct packed {
    logic       op;
    logic [7:0] b;
  } ts_item_t;

  typedef enum int {ST_SEARCH, ST_HEADER, ST_NAME, ST_BODY} ext_state_t;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_WAIT     = 10;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // stream_byte
  logic        s_axis_tuser;   // opcode
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [79:0] m_axis_tdata;   // data_byte, announced_size, announced_name_length
  logic [2:0]  m_axis_tuser;   // kind
  logic        m_axis_tlast;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  ts_embedded_file_extractor u_dut (.*);

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  ts_item_t   ts_pending[$];
  result_t    extract_q[$];
  logic [7:0] content_q[$];

  int tx_idle_pct;
  int rx_idle_pct;
  bit rx_hold;
  bit in_taken;
  int errors;
  int items_in;
  int results_seen;
  int quiet_cycles;

  // predictor state
  logic [12:0] pid_reg;
  logic [7:0]  pkt_mem[PACKET_BYTES];
  bit          replay_ok;
  int          load_pos;
  bit          drained;
  bit          d_acc, d_sync, d_adapt;
  int          d_start;
  ext_state_t  ext_st;
  int          mprog;
  int          hprog;
  logic [63:0] name_len, body_len, done_cnt;
  bit          skip_pkt;

  function automatic int magic_advance(int q, logic [7:0] b);
    bit ok;
    for (int k = q + 1; k > 0; k--) begin
      if (k > MAGIC_LENGTH) continue;
      if (MAGIC[k-1] != b) continue;
      ok = 1;
      for (int j = 0; j + 1 < k; j++) begin
        if (MAGIC[j] != MAGIC[(q + 1 - k + j) & 15]) ok = 0;
      end
      if (ok) return k;
    end
    return 0;
  endfunction

  function automatic void describe_packet();
    int pid, afc, p, psize, skip, h;
    d_acc = 0; d_sync = 0; d_adapt = 0; d_start = 0; skip = 0;
    if (pkt_mem[0] != SYNC_VALUE) begin
      d_sync = 1;
      return;
    end
    pid = {pkt_mem[1][4:0], pkt_mem[2]};
    if (pid != pid_reg) return;
    afc = pkt_mem[3][5:4];
    if (afc == 1) p = 4;
    else if (afc == 3) begin
      p = 5 + pkt_mem[4];
      if (p > PACKET_BYTES) begin
        d_adapt = 1;
        return;
      end
    end else return;
    psize = PACKET_BYTES - p;
    if (psize >= 9 && pkt_mem[p] == 0 && pkt_mem[p+1] == 0 && pkt_mem[p+2] == 1 &&
        pkt_mem[p+3] == PES_AUDIO_ID) begin
      h = 9 + pkt_mem[p+8];
      if (h + 7 <= psize && pkt_mem[p+h] == AC3_FIRST && pkt_mem[p+h+1] == AC3_SECOND)
        skip = h + 7;
    end
    d_acc = 1;
    d_start = (p + skip) & 8'hFF;
  endfunction

  function automatic void restart_search(bit skip);
    ext_st = ST_SEARCH; mprog = 0; hprog = 0; done_cnt = 0;
    if (skip) skip_pkt = 1;
  endfunction

  function automatic bit extract_step(logic op, logic [7:0] b, output result_t r);
    int pos;
    bit got;
    logic [7:0] v;
    got = 0; r = '0; pos = load_pos;
    if (replay_ok) begin
      v = pkt_mem[pos];
      if (pos == 0) begin
        skip_pkt = 0;
        if (d_sync) begin got = 1; r.kind = KIND_SYNC_ERR; end
        else if (d_adapt) begin got = 1; r.kind = KIND_ADAPT_ERR; end
      end else if (d_acc && !skip_pkt && pos >= d_start) begin
        case (ext_st)
          ST_SEARCH: begin
            mprog = magic_advance(mprog, v);
            if (mprog >= MAGIC_LENGTH) begin
              ext_st = ST_HEADER; mprog = 0; hprog = 0; name_len = 0; body_len = 0;
            end
          end
          ST_HEADER: begin
            if (hprog >= 2 && hprog < 10) name_len |= 64'(v) << (8 * (hprog - 2));
            else if (hprog >= 10 && hprog < 18) body_len |= 64'(v) << (8 * (hprog - 10));
            hprog++;
            if (hprog >= HEADER_BYTES) begin
              hprog = 0; got = 1;
              if (name_len > MAX_NAME_LENGTH) begin
                restart_search(0);
                r.kind = KIND_NAME_LONG;
              end else begin
                done_cnt = 0;
                if (name_len > 0) ext_st = ST_NAME;
                else if (body_len > 0) ext_st = ST_BODY;
                else restart_search(1);
                r.kind = KIND_ANNOUNCE;
                r.announced_size = body_len;
                r.announced_name_length = name_len[7:0];
              end
            end
          end
          ST_NAME: begin
            got = 1; r.kind = KIND_NAME; r.data_byte = v;
            done_cnt++;
            if (done_cnt >= name_len) begin
              done_cnt = 0; r.last = 1;
              if (body_len > 0) ext_st = ST_BODY;
              else restart_search(1);
            end
          end
          default: begin
            got = 1; r.kind = KIND_FILE; r.data_byte = v;
            done_cnt++;
            if (done_cnt >= body_len) begin
              r.last = 1;
              restart_search(1);
            end
          end
        endcase
      end
    end
    if (op == OP_BYTE) pkt_mem[pos] = b;
    else drained = 1;
    pos++;
    if (pos >= PACKET_BYTES) begin
      pos = 0;
      if (!drained) begin
        replay_ok = 1;
        describe_packet();
      end else replay_ok = 0;
      drained = 0;
    end
    load_pos = pos;
    return got;
  endfunction

  // input acceptance, prediction and result checking
  always @(posedge clk) begin
    result_t exp_r, act_r;
    in_taken <= s_axis_tvalid && s_axis_tready && !rst;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        items_in++;
        if (extract_step(s_axis_tuser, s_axis_tdata, exp_r)) extract_q.push_back(exp_r);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        act_r.kind = kind_t'(m_axis_tuser);
        act_r.data_byte = m_axis_tdata[7:0];
        act_r.announced_size = m_axis_tdata[71:8];
        act_r.announced_name_length = m_axis_tdata[79:72];
        act_r.last = m_axis_tlast;
        if (extract_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result: kind %0d data %h", act_r.kind,
                                     act_r.data_byte);
        end else begin
          exp_r = extract_q.pop_front();
          if (act_r !== exp_r) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch: exp kind %0d data %h size %h nlen %0d last %b",
                       exp_r.kind, exp_r.data_byte, exp_r.announced_size,
                       exp_r.announced_name_length, exp_r.last);
              $display("          act kind %0d data %h size %h nlen %0d last %b",
                       act_r.kind, act_r.data_byte, act_r.announced_size,
                       act_r.announced_name_length, act_r.last);
            end
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout");
      $display("Mismatches found");
      $finish;
    end
  end

  // stream driver
  always @(negedge clk) begin
    ts_item_t it;
    if (!rst && (!s_axis_tvalid || in_taken)) begin
      if (ts_pending.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
        it = ts_pending.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= it.op;
        s_axis_tdata <= it.b;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    m_axis_tready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
  end

  initial begin
    rx_hold = 0;
    wait (items_in > 300);
    rx_hold = 1;
    repeat (400) @(posedge clk);
    rx_hold = 0;
  end

  // idle regimes follow the number of accepted items
  initial begin
    tx_idle_pct = 38; rx_idle_pct = 66;
    wait (items_in >= 220);
    tx_idle_pct = 66; rx_idle_pct = 38;
    wait (items_in >= 440);
    tx_idle_pct = 0; rx_idle_pct = 0;
  end

  task automatic write_pid(input logic [12:0] v);
    @(negedge clk);
    psel <= 1; pwrite <= 1; penable <= 0; paddr <= 3'd0; pwdata <= {$urandom} & ~32'h1FFF | v;
    @(negedge clk);
    penable <= 1;
    @(posedge clk);
    pid_reg = v;
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  task automatic queue_file(input logic [63:0] nlen, input logic [63:0] size);
    longint n;
    for (int i = 0; i < MAGIC_LENGTH; i++) content_q.push_back(MAGIC[i]);
    content_q.push_back(8'($urandom));
    content_q.push_back(8'($urandom));
    for (int i = 0; i < 8; i++) content_q.push_back(nlen[8*i +: 8]);
    for (int i = 0; i < 8; i++) content_q.push_back(size[8*i +: 8]);
    if (nlen > MAX_NAME_LENGTH) return;
    for (int i = 0; i < nlen; i++) content_q.push_back(8'($urandom));
    n = (size > 400) ? 400 : size;
    for (longint i = 0; i < n; i++) content_q.push_back(8'($urandom));
  endtask

  // noise with a partial magic, so the matcher has to fall back
  task automatic queue_noise();
    int n;
    n = $urandom_range(0, 6);
    for (int i = 0; i < n; i++) content_q.push_back(8'($urandom));
    n = $urandom_range(0, 11);
    for (int i = 0; i < n; i++) content_q.push_back(MAGIC[i]);
  endtask

  task automatic queue_packet(input logic [12:0] pid, input int afc, input int alen,
                              input bit pes, input bit bad_sync, input bit may_drain);
    logic [7:0] pk[PACKET_BYTES];
    int p, hl, di;
    bit feed;
    ts_item_t it;
    pk[0] = bad_sync ? (SYNC_VALUE ^ 8'($urandom_range(1, 255))) : SYNC_VALUE;
    pk[1] = {3'($urandom), pid[12:8]};
    pk[2] = pid[7:0];
    pk[3] = {2'($urandom), 2'(afc), 4'($urandom)};
    p = 4;
    feed = !bad_sync && (afc == 1 || (afc == 3 && alen <= 183));
    if (afc == 3) begin
      pk[4] = 8'(alen);
      p = 5;
      for (int i = 0; i < alen && p < PACKET_BYTES; i++) pk[p++] = 8'($urandom);
    end
    if (feed && pes) begin
      hl = $urandom_range(0, 3);
      if (p + 16 + hl <= PACKET_BYTES) begin
        pk[p] = 0; pk[p+1] = 0; pk[p+2] = 1; pk[p+3] = PES_AUDIO_ID;
        for (int i = 4; i < 8; i++) pk[p+i] = 8'($urandom);
        pk[p+8] = 8'(hl);
        for (int i = 0; i < hl; i++) pk[p+9+i] = 8'($urandom);
        pk[p+9+hl] = AC3_FIRST;
        pk[p+10+hl] = ($urandom_range(3) == 0) ? 8'h00 : AC3_SECOND;
        for (int i = 0; i < 5; i++) pk[p+11+hl+i] = 8'($urandom);
        p += 16 + hl;
      end
    end
    while (p < PACKET_BYTES) begin
      pk[p] = (feed && content_q.size() > 0) ? content_q.pop_front() : 8'($urandom);
      p++;
    end
    di = (may_drain && $urandom_range(99) < 4) ? $urandom_range(0, PACKET_BYTES - 1) : -1;
    for (int i = 0; i < PACKET_BYTES; i++) begin
      it.op = (i == di) ? OP_DRAIN : OP_BYTE;
      it.b = (i == di) ? 8'($urandom) : pk[i];
      ts_pending.push_back(it);
    end
  endtask

  task automatic flush_and_settle(input int n);
    ts_item_t it;
    for (int i = 0; i < n; i++) begin
      it.op = OP_DRAIN;
      it.b = 8'($urandom);
      ts_pending.push_back(it);
    end
    wait (ts_pending.size() == 0);
    @(negedge clk);
    wait (!s_axis_tvalid);
    wait (extract_q.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  initial begin
    logic [12:0] pid;
    rst = 1;
    s_axis_tvalid = 0; s_axis_tdata = 0; s_axis_tuser = 0; m_axis_tready = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    errors = 0; items_in = 0; results_seen = 0; quiet_cycles = 0; in_taken = 0;
    pid_reg = PID_RESET;
    replay_ok = 0; load_pos = 0; drained = 0; d_acc = 0; d_sync = 0; d_adapt = 0;
    d_start = 0; ext_st = ST_SEARCH; mprog = 0; hprog = 0; name_len = 0; body_len = 0;
    done_cnt = 0; skip_pkt = 0;
    for (int i = 0; i < PACKET_BYTES; i++) pkt_mem[i] = 0;
    repeat (12) @(posedge clk);
    rst = 0;

    pid = 13'($urandom);
    write_pid(pid);

    // a rejected header, then a file that spans two payload packets
    queue_noise();
    queue_file(64'd255 + 64'($urandom_range(0, 3)), 64'd1);
    queue_file(64'd3, 64'd200);
    queue_packet(pid, 1, 0, 1, 0, 0);
    queue_packet(pid, 3, 20, 1, 0, 0);
    // broken sync on a foreign PID still reports
    queue_packet(pid ^ 13'd1, 1, 0, 0, 1, 0);
    flush_and_settle(100);

    $display("run covered %0d stream items and %0d results: header search across packets,",
             items_in, results_seen);
    $display("PES skip, long name rejection, sync error, drain replay and output stalls");
    if (extract_q.size() != 0) errors += extract_q.size();
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d errors", errors);
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
